// ===== rtl/btp_pkg.sv =====
// ----------------------------------------------------------------------------
// btp_pkg
// Shared constants and types of the BER-TLV stream parser: result kinds,
// error codes, end-offset stack size and the stack command/status groups.
// ----------------------------------------------------------------------------
package btp_pkg;

  localparam int MAX_DEPTH = 8;
  localparam int OFF_W     = 32;
  localparam int NEST_W    = 4;

  localparam logic [1:0] KIND_HDR_BYTE = 2'd0;
  localparam logic [1:0] KIND_ELEMENT  = 2'd1;
  localparam logic [1:0] KIND_VALUE    = 2'd2;
  localparam logic [1:0] KIND_ERROR    = 2'd3;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_TAG_LONG  = 3'd1;
  localparam logic [2:0] ERR_LEN_LONG  = 3'd2;
  localparam logic [2:0] ERR_TRUNC     = 3'd3;
  localparam logic [2:0] ERR_TOO_DEEP  = 3'd4;

  localparam logic [4:0] TAG_ESCAPE    = 5'h1F;
  localparam logic [6:0] LEN_MAX_BYTES = 7'd4;
  localparam logic [OFF_W-1:0] OFF_MAX = {OFF_W{1'b1}};

  typedef struct packed {
    logic             push;
    logic             pop;
    logic             flush;
    logic [OFF_W-1:0] off;
    logic [OFF_W-1:0] push_end;
  } stk_cmd_t;

  typedef struct packed {
    logic [OFF_W-1:0]  top_end;
    logic [NEST_W-1:0] depth;
    logic [NEST_W-1:0] pop_depth;
    logic              nonempty;
    logic              full;
  } stk_stat_t;

endpackage

// ===== rtl/btp_if.sv =====
// ----------------------------------------------------------------------------
// btp_in_if / btp_out_if
// Valid/ready channels of the parser: raw input bytes and per-byte results.
// ----------------------------------------------------------------------------
interface btp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface btp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [23:0] tag_value;
  logic [1:0]  tag_size;
  logic [31:0] element_length;
  logic        is_constructed;
  logic [3:0]  nest_depth;
  logic [7:0]  value_out;
  logic [2:0]  error_code;
  logic        buffer_done;

  modport source (output valid, output kind, output tag_value, output tag_size,
                  output element_length, output is_constructed, output nest_depth,
                  output value_out, output error_code, output buffer_done,
                  input ready);
  modport sink   (input valid, input kind, input tag_value, input tag_size,
                  input element_length, input is_constructed, input nest_depth,
                  input value_out, input error_code, input buffer_done,
                  output ready);
endinterface

// ===== rtl/btp_cell.sv =====
// ----------------------------------------------------------------------------
// btp_cell
// One level of the end-offset stack. Holds the end offset of one open
// constructed element and talks to its neighbors below and above.
// ----------------------------------------------------------------------------
module btp_cell
  import btp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  stk_cmd_t         cmd,
  input  logic             below_valid,
  input  logic             below_keep,
  input  logic             above_valid,
  input  logic [OFF_W-1:0] top_in,
  output logic             valid_o,
  output logic             keep_o,
  output logic [OFF_W-1:0] top_out
);

  logic             valid_r;
  logic             valid_nxt;
  logic [OFF_W-1:0] end_r;
  logic             is_top;
  logic             load;

  // open elements nest, so the kept cells always form a run from the bottom
  assign keep_o  = below_keep & valid_r & (end_r > cmd.off);
  assign is_top  = valid_r & ~above_valid;
  assign top_out = top_in | (is_top ? end_r : '0);
  assign valid_o = valid_r;

  // first free cell takes the pushed end
  assign load = cmd.push & below_valid & ~valid_r;

  always_comb begin
    valid_nxt = valid_r;
    if (cmd.flush) begin
      valid_nxt = 1'b0;
    end else if (cmd.pop) begin
      valid_nxt = keep_o;
    end else if (load) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (load && !cmd.flush) begin
        end_r <= cmd.push_end;
      end
    end
  end

endmodule

// ===== rtl/btp_stack.sv =====
// ----------------------------------------------------------------------------
// btp_stack
// Row of MAX_DEPTH cells forming the end-offset stack of open constructed
// elements, with depth counts and the end offset of the innermost one.
// ----------------------------------------------------------------------------
module btp_stack
  import btp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  stk_cmd_t  cmd,
  output stk_stat_t stat
);

  logic [MAX_DEPTH-1:0] valid;
  logic [MAX_DEPTH-1:0] keep;
  logic [MAX_DEPTH-1:0] below_valid;
  logic [MAX_DEPTH-1:0] below_keep;
  logic [OFF_W-1:0]     top_chain [MAX_DEPTH+1];
  logic [MAX_DEPTH-1:0] above_valid;
  logic [NEST_W-1:0]    depth_cnt;
  logic [NEST_W-1:0]    keep_cnt;

  assign below_valid[0] = 1'b1;
  assign below_keep[0]  = 1'b1;
  assign top_chain[0]   = '0;

  for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_cell
    if (i == MAX_DEPTH - 1) begin : g_last
      assign above_valid[i] = 1'b0;
    end else begin : g_mid
      assign above_valid[i]   = valid[i+1];
      assign below_valid[i+1] = valid[i];
      assign below_keep[i+1]  = keep[i];
    end

    btp_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .below_valid (below_valid[i]),
      .below_keep  (below_keep[i]),
      .above_valid (above_valid[i]),
      .top_in      (top_chain[i]),
      .valid_o     (valid[i]),
      .keep_o      (keep[i]),
      .top_out     (top_chain[i+1])
    );
  end

  always_comb begin
    depth_cnt = '0;
    keep_cnt  = '0;
    for (int i = 0; i < MAX_DEPTH; i++) begin
      depth_cnt = depth_cnt + NEST_W'(valid[i]);
      keep_cnt  = keep_cnt + NEST_W'(keep[i]);
    end
  end

  assign stat.top_end   = top_chain[MAX_DEPTH];
  assign stat.depth     = depth_cnt;
  assign stat.pop_depth = keep_cnt;
  assign stat.nonempty  = valid[0];
  assign stat.full      = valid[MAX_DEPTH-1];

endmodule

// ===== rtl/ber_tlv_stream_parser.sv =====
// ----------------------------------------------------------------------------
// ber_tlv_stream_parser
// BER-TLV byte stream parser giving one result item per input byte.
// ----------------------------------------------------------------------------
// Takes one byte per clock and returns its result in the cycle after it is
// accepted, through an output register, so a steady stream runs at one byte
// per cycle; a stalled output holds the input back only when the register is
// full and not being taken. Nesting is tracked in a row of MAX_DEPTH stack
// cells; the end-offset compares of all cells and the clamp of a child's
// length against its parent's end set the critical path of that cycle.
// Errors are sticky until the byte flagged last, after which all parse state
// returns to its reset values.
module ber_tlv_stream_parser
  import btp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  btp_in_if.sink           in_chan,
  btp_out_if.source        out_chan
);

  typedef enum logic [2:0] {
    PH_TAG_FIRST,
    PH_TAG_NEXT,
    PH_LEN_FIRST,
    PH_LEN_MORE,
    PH_VALUE,
    PH_ERROR
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [23:0]      tag_acc_r, tag_acc_nxt;
  logic [1:0]       tag_cnt_r, tag_cnt_nxt;
  logic [31:0]      len_acc_r, len_acc_nxt;
  logic [2:0]       len_left_r, len_left_nxt;
  logic             cons_r, cons_nxt;
  logic [OFF_W-1:0] off_r, off_nxt;
  logic [OFF_W-1:0] prim_end_r, prim_end_nxt;
  logic [2:0]       err_r, err_nxt;

  logic        out_valid_r;
  logic [1:0]  kind_r;
  logic [23:0] tag_value_r;
  logic [1:0]  tag_size_r;
  logic [31:0] elen_r;
  logic        cons_out_r;
  logic [3:0]  depth_r;
  logic [7:0]  vout_r;
  logic [2:0]  errc_r;
  logic        done_r;

  logic [1:0]       kind_c;
  logic [23:0]      tagv_c;
  logic [1:0]       tsz_c;
  logic [31:0]      elen_c;
  logic             cons_c;
  logic [3:0]       depth_c;
  logic [7:0]       vout_c;
  logic [2:0]       err_c;
  logic             hdr_done;
  logic [31:0]      len_c;
  logic             pop_c;
  logic             push_c;

  logic             accept;
  logic [7:0]       b;
  logic             last;
  logic             past;
  logic [OFF_W:0]   next_off;
  logic [OFF_W+1:0] end_raw;
  logic [OFF_W+1:0] end_clamp;
  logic [OFF_W-1:0] end_sat;
  logic [31:0]      el_c;

  stk_cmd_t  stk_cmd;
  stk_stat_t stk_stat;

  btp_stack u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (stk_cmd),
    .stat  (stk_stat)
  );

  assign in_chan.ready = ~out_valid_r | out_chan.ready;
  assign accept        = in_chan.valid & in_chan.ready;
  assign b             = in_chan.data_byte;
  assign last          = in_chan.last_byte;

  assign past     = stk_stat.nonempty & (off_r >= stk_stat.top_end);
  assign next_off = {1'b0, off_r} + 1'b1;

  // end of the new element, clamped to the parent and saturated at the top
  always_comb begin
    end_raw   = {1'b0, next_off} + {2'b00, len_c};
    end_clamp = end_raw;
    el_c      = len_c;
    if (stk_stat.nonempty) begin
      if (end_raw > {2'b00, stk_stat.top_end}) begin
        end_clamp = {2'b00, stk_stat.top_end};
      end
      el_c = 32'(end_clamp - {1'b0, next_off});
    end
    end_sat = (end_clamp > {2'b00, OFF_MAX}) ? OFF_MAX : end_clamp[OFF_W-1:0];
  end

  always_comb begin
    phase_nxt    = phase_r;
    tag_acc_nxt  = tag_acc_r;
    tag_cnt_nxt  = tag_cnt_r;
    len_acc_nxt  = len_acc_r;
    len_left_nxt = len_left_r;
    cons_nxt     = cons_r;
    prim_end_nxt = prim_end_r;
    err_nxt      = err_r;
    off_nxt      = (off_r == OFF_MAX) ? off_r : off_r + 1'b1;

    kind_c   = KIND_HDR_BYTE;
    tagv_c   = '0;
    tsz_c    = '0;
    elen_c   = '0;
    cons_c   = 1'b0;
    depth_c  = stk_stat.depth;
    vout_c   = '0;
    err_c    = ERR_NONE;
    hdr_done = 1'b0;
    len_c    = '0;
    pop_c    = 1'b0;
    push_c   = 1'b0;

    case (phase_r)
      PH_TAG_FIRST: begin
        // close every open element that ends here
        pop_c       = 1'b1;
        depth_c     = stk_stat.pop_depth;
        tag_acc_nxt = {16'd0, b};
        tag_cnt_nxt = 2'd1;
        cons_nxt    = b[5];
        phase_nxt   = (b[4:0] == TAG_ESCAPE) ? PH_TAG_NEXT : PH_LEN_FIRST;
      end
      PH_TAG_NEXT: begin
        if (past) begin
          err_c = ERR_TRUNC;
        end else begin
          tag_acc_nxt = {tag_acc_r[15:0], b};
          tag_cnt_nxt = tag_cnt_r + 2'd1;
          if (b[7]) begin
            if (tag_cnt_nxt == 2'd3) begin
              err_c = ERR_TAG_LONG;
            end
          end else begin
            phase_nxt = PH_LEN_FIRST;
          end
        end
      end
      PH_LEN_FIRST: begin
        if (past) begin
          err_c = ERR_TRUNC;
        end else if (b[7]) begin
          if (b[6:0] > LEN_MAX_BYTES) begin
            err_c = ERR_LEN_LONG;
          end else if (b[6:0] == 7'd0) begin
            hdr_done = 1'b1;
          end else begin
            len_acc_nxt  = '0;
            len_left_nxt = b[2:0];
            phase_nxt    = PH_LEN_MORE;
          end
        end else begin
          len_c    = {24'd0, b};
          hdr_done = 1'b1;
        end
      end
      PH_LEN_MORE: begin
        if (past) begin
          err_c = ERR_TRUNC;
        end else begin
          len_acc_nxt  = {len_acc_r[23:0], b};
          len_left_nxt = len_left_r - 3'd1;
          if (len_left_nxt == 3'd0) begin
            len_c    = len_acc_nxt;
            hdr_done = 1'b1;
          end
        end
      end
      PH_VALUE: begin
        kind_c = KIND_VALUE;
        vout_c = b;
        if (next_off >= {1'b0, prim_end_r}) begin
          phase_nxt = PH_TAG_FIRST;
        end
      end
      default: begin
        kind_c = KIND_ERROR;
        err_c  = err_r;
      end
    endcase

    if (hdr_done) begin
      if (cons_r && stk_stat.full) begin
        err_c = ERR_TOO_DEEP;
      end else begin
        kind_c = KIND_ELEMENT;
        tagv_c = tag_acc_r;
        tsz_c  = tag_cnt_r;
        elen_c = el_c;
        cons_c = cons_r;
        if (cons_r) begin
          push_c    = 1'b1;
          phase_nxt = PH_TAG_FIRST;
        end else if (el_c == 32'd0) begin
          phase_nxt = PH_TAG_FIRST;
        end else begin
          prim_end_nxt = end_sat;
          phase_nxt    = PH_VALUE;
        end
      end
    end

    // buffer ends in the middle of a header
    if (err_c == ERR_NONE && last &&
        (phase_nxt inside {PH_TAG_NEXT, PH_LEN_FIRST, PH_LEN_MORE})) begin
      err_c = ERR_TRUNC;
    end

    if (err_c != ERR_NONE) begin
      kind_c    = KIND_ERROR;
      tagv_c    = '0;
      tsz_c     = '0;
      elen_c    = '0;
      cons_c    = 1'b0;
      vout_c    = '0;
      err_nxt   = err_c;
      phase_nxt = PH_ERROR;
    end
  end

  always_comb begin
    stk_cmd.push     = accept & push_c & (err_c == ERR_NONE);
    stk_cmd.pop      = accept & pop_c;
    stk_cmd.flush    = accept & last;
    stk_cmd.off      = off_r;
    stk_cmd.push_end = end_sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_TAG_FIRST;
      off_r       <= '0;
      err_r       <= ERR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        tag_acc_r  <= tag_acc_nxt;
        tag_cnt_r  <= tag_cnt_nxt;
        len_acc_r  <= len_acc_nxt;
        len_left_r <= len_left_nxt;
        cons_r     <= cons_nxt;
        prim_end_r <= prim_end_nxt;
        if (last) begin
          phase_r <= PH_TAG_FIRST;
          off_r   <= '0;
          err_r   <= ERR_NONE;
        end else begin
          phase_r <= phase_nxt;
          off_r   <= off_nxt;
          err_r   <= err_nxt;
        end

        out_valid_r <= 1'b1;
        kind_r      <= kind_c;
        tag_value_r <= tagv_c;
        tag_size_r  <= tsz_c;
        elen_r      <= elen_c;
        cons_out_r  <= cons_c;
        depth_r     <= depth_c;
        vout_r      <= vout_c;
        errc_r      <= err_c;
        done_r      <= last;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.kind           = kind_r;
  assign out_chan.tag_value      = tag_value_r;
  assign out_chan.tag_size       = tag_size_r;
  assign out_chan.element_length = elen_r;
  assign out_chan.is_constructed = cons_out_r;
  assign out_chan.nest_depth     = depth_r;
  assign out_chan.value_out      = vout_r;
  assign out_chan.error_code     = errc_r;
  assign out_chan.buffer_done    = done_r;

endmodule

// ===== tb/btp_checker.sv =====
// ----------------------------------------------------------------------------
// btp_checker
// Watches both channels of the BER-TLV stream parser, predicts the result item
// of every accepted input byte with a cycle-free model of the parse, and
// compares each accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module btp_checker
  import btp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  btp_in_if    in_mon,
  btp_out_if   out_mon,
  output int   fail_count,
  output int   pending,
  output int   n_elem,
  output int   n_value,
  output int   n_error,
  output int   deepest
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    ST_TAG0, ST_TAGN, ST_LEN0, ST_LENN, ST_BODY, ST_HALT
  } parse_st_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [23:0] tag_value;
    logic [1:0]  tag_size;
    logic [31:0] element_length;
    logic        is_constructed;
    logic [3:0]  nest_depth;
    logic [7:0]  value_out;
    logic [2:0]  error_code;
    logic        buffer_done;
  } tlv_token_t;

  parse_st_t        phase;
  logic [23:0]      tag_acc;
  logic [1:0]       tag_cnt;
  logic [31:0]      len_acc;
  logic [2:0]       len_left;
  logic             cons_flag;
  logic [OFF_W-1:0] byte_pos;
  logic [OFF_W-1:0] end_stack [MAX_DEPTH];
  int               open_cnt;
  logic [OFF_W-1:0] prim_end;
  logic [2:0]       err_hold;

  tlv_token_t token_q[$];
  int fails = 0, elems = 0, values = 0, errs = 0, max_nest = 0;

  function automatic void clear_parser();
    phase     = ST_TAG0;
    tag_acc   = '0;
    tag_cnt   = '0;
    len_acc   = '0;
    len_left  = '0;
    cons_flag = 1'b0;
    byte_pos  = '0;
    for (int i = 0; i < MAX_DEPTH; i++) end_stack[i] = '0;
    open_cnt  = 0;
    prim_end  = '0;
    err_hold  = ERR_NONE;
  endfunction

  function automatic void put_token(input tlv_token_t t);
    token_q.insert(token_q.size(), t);
  endfunction

  function automatic tlv_token_t parse_byte(input logic [7:0] b, input logic last);
    tlv_token_t       t;
    logic [OFF_W-1:0] off;
    logic [OFF_W-1:0] parent_end;
    logic             past;
    logic [2:0]       err;
    logic             fin;
    logic [31:0]      len;
    logic [33:0]      nxt, stop, elen;
    t          = '0;
    off        = byte_pos;
    err        = ERR_NONE;
    fin        = 1'b0;
    len        = '0;
    t.nest_depth = open_cnt[3:0];
    parent_end = (open_cnt > 0) ? end_stack[open_cnt-1] : '0;
    past       = (open_cnt > 0) && (off >= parent_end);

    case (phase)
      ST_TAG0: begin
        // close every constructed element that ended at or before this byte
        while (open_cnt > 0 && end_stack[open_cnt-1] <= off) open_cnt--;
        t.nest_depth = open_cnt[3:0];
        tag_acc   = {16'h0, b};
        tag_cnt   = 2'd1;
        cons_flag = b[5];
        phase     = (b[4:0] == TAG_ESCAPE) ? ST_TAGN : ST_LEN0;
      end
      ST_TAGN: begin
        if (past) begin
          err = ERR_TRUNC;
        end else begin
          tag_acc = {tag_acc[15:0], b};
          tag_cnt = tag_cnt + 2'd1;
          if (b[7]) begin
            if (tag_cnt == 2'd3) err = ERR_TAG_LONG;
          end else begin
            phase = ST_LEN0;
          end
        end
      end
      ST_LEN0: begin
        if (past) begin
          err = ERR_TRUNC;
        end else if (b[7]) begin
          if (b[6:0] > LEN_MAX_BYTES) begin
            err = ERR_LEN_LONG;
          end else if (b[6:0] == 7'd0) begin
            fin = 1'b1;
          end else begin
            len_acc  = '0;
            len_left = b[2:0];
            phase    = ST_LENN;
          end
        end else begin
          len = {24'h0, b};
          fin = 1'b1;
        end
      end
      ST_LENN: begin
        if (past) begin
          err = ERR_TRUNC;
        end else begin
          len_acc  = {len_acc[23:0], b};
          len_left = len_left - 3'd1;
          if (len_left == 3'd0) begin
            len = len_acc;
            fin = 1'b1;
          end
        end
      end
      ST_BODY: begin
        t.kind      = KIND_VALUE;
        t.value_out = b;
        if ({1'b0, off} + 33'd1 >= {1'b0, prim_end}) phase = ST_TAG0;
      end
      default: begin
        t.kind = KIND_ERROR;
        err    = err_hold;
      end
    endcase

    if (fin) begin
      nxt  = {2'b0, off} + 34'd1;
      stop = nxt + {2'b0, len};
      elen = {2'b0, len};
      // children are clamped to the parent end, top level only saturates
      if (open_cnt > 0) begin
        if (stop > {2'b0, parent_end}) stop = {2'b0, parent_end};
        elen = stop - nxt;
      end
      if (stop > {2'b0, OFF_MAX}) stop = {2'b0, OFF_MAX};
      if (cons_flag && open_cnt >= MAX_DEPTH) begin
        err = ERR_TOO_DEEP;
      end else begin
        t.kind           = KIND_ELEMENT;
        t.tag_value      = tag_acc;
        t.tag_size       = tag_cnt;
        t.element_length = elen[31:0];
        t.is_constructed = cons_flag;
        t.nest_depth     = open_cnt[3:0];
        if (cons_flag) begin
          end_stack[open_cnt] = stop[31:0];
          open_cnt++;
          phase = ST_TAG0;
        end else if (elen == 34'd0) begin
          phase = ST_TAG0;
        end else begin
          prim_end = stop[31:0];
          phase    = ST_BODY;
        end
      end
    end

    if (err == ERR_NONE && last && (phase inside {ST_TAGN, ST_LEN0, ST_LENN}))
      err = ERR_TRUNC;

    if (err != ERR_NONE) begin
      t.kind           = KIND_ERROR;
      t.tag_value      = '0;
      t.tag_size       = '0;
      t.element_length = '0;
      t.is_constructed = 1'b0;
      t.value_out      = '0;
      err_hold         = err;
      phase            = ST_HALT;
    end
    t.error_code  = err;
    t.buffer_done = last;

    if (byte_pos != OFF_MAX) byte_pos = byte_pos + 1'b1;
    if (last) clear_parser();
    return t;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    tlv_token_t want;
    if (!rst_n) begin
      clear_parser();
      token_q.delete();
    end else begin
      // a result always belongs to a byte taken at an earlier edge
      if (out_mon.valid && out_mon.ready) begin
        if (token_q.size() == 0) begin
          $error("result item with no byte waiting for it");
          fails++;
        end else begin
          want = token_q.pop_front();
          check_field("kind", 32'(want.kind), 32'(out_mon.kind));
          check_field("tag_value", 32'(want.tag_value), 32'(out_mon.tag_value));
          check_field("tag_size", 32'(want.tag_size), 32'(out_mon.tag_size));
          check_field("element_length", want.element_length, out_mon.element_length);
          check_field("is_constructed", 32'(want.is_constructed),
                      32'(out_mon.is_constructed));
          check_field("nest_depth", 32'(want.nest_depth), 32'(out_mon.nest_depth));
          check_field("value_out", 32'(want.value_out), 32'(out_mon.value_out));
          check_field("error_code", 32'(want.error_code), 32'(out_mon.error_code));
          check_field("buffer_done", 32'(want.buffer_done), 32'(out_mon.buffer_done));
          case (want.kind)
            KIND_ELEMENT: begin
              elems++;
              if (int'(want.nest_depth) > max_nest) max_nest = int'(want.nest_depth);
            end
            KIND_VALUE: values++;
            KIND_ERROR: errs++;
            default: ;
          endcase
        end
      end
      if (in_mon.valid && in_mon.ready)
        put_token(parse_byte(in_mon.data_byte, in_mon.last_byte));
    end
    fail_count <= fails;
    pending    <= token_q.size();
    n_elem     <= elems;
    n_value    <= values;
    n_error    <= errs;
    deepest    <= max_nest;
  end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Byte stream stimulus for the BER-TLV stream parser: a few hand-built buffers
// for the error and nesting corner cases, then random buffers of mostly
// well-formed TLV trees with noise and cut-off buffers mixed in, run through
// four flow-control modes. The checker beside the block does all comparing.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BYTES = 1500;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;
  // one constructed level more than the block can hold
  localparam int MAX_NEST_TRY = btp_pkg::MAX_DEPTH + 1;

  typedef enum int {MODE_STEADY, MODE_SLOW_SRC, MODE_SLOW_SINK, MODE_BOTH} flow_mode_t;

  logic clk;
  logic rst_n;

  btp_in_if  in_if();
  btp_out_if out_if();

  int fail_count, pending, n_elem, n_value, n_error, deepest;
  int idle_pct, stall_pct;
  int bytes_sent, buffers_sent, cycles;

  ber_tlv_stream_parser u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  btp_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .fail_count (fail_count),
    .pending    (pending),
    .n_elem     (n_elem),
    .n_value    (n_value),
    .n_error    (n_error),
    .deepest    (deepest)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side stalls
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
    $display("*** FAILED ***");
    $finish;
  end

  function automatic void set_mode(input flow_mode_t m);
    case (m)
      MODE_STEADY:    begin idle_pct = 0;  stall_pct = 0;  end
      MODE_SLOW_SRC:  begin idle_pct = 81; stall_pct = 0;  end
      MODE_SLOW_SINK: begin idle_pct = 0;  stall_pct = 81; end
      default:        begin idle_pct = 27; stall_pct = 27; end
    endcase
  endfunction

  function automatic void add_byte(ref logic [7:0] q[$], input logic [7:0] v);
    q.insert(q.size(), v);
  endfunction

  // one element with a random tag, length encoding and body; the declared
  // length is sometimes off so that clamping and misparses get exercised
  function automatic void gen_elem(input int lvl, input int max_lvl, input bit deep,
                                   ref logic [7:0] q[$]);
    logic [7:0]  body[$];
    logic [7:0]  t0, tb;
    logic [31:0] len;
    bit          cons;
    int          tsz, n, r, nmin, nb;
    cons = (lvl < max_lvl) && (deep || $urandom_range(1) == 1);
    r    = $urandom_range(9);
    tsz  = (r < 7) ? 1 : (r < 9) ? 2 : 3;
    t0   = 8'($urandom);
    t0[5] = cons;
    if (tsz > 1) t0[4:0] = 5'h1F;
    else if (t0[4:0] == 5'h1F) t0[0] = 1'b0;
    add_byte(q, t0);
    for (int i = 2; i <= tsz; i++) begin
      tb    = 8'($urandom);
      tb[7] = (i < tsz);
      add_byte(q, tb);
    end
    if (cons) begin
      n = (deep && lvl >= 1) ? 1 : $urandom_range(0, 3);
      for (int i = 0; i < n; i++) gen_elem(lvl + 1, max_lvl, deep, body);
    end else begin
      n = ($urandom_range(24) == 0) ? $urandom_range(128, 300) : $urandom_range(0, 6);
      for (int i = 0; i < n; i++) add_byte(body, 8'($urandom));
    end
    len = body.size();
    r   = $urandom_range(99);
    if (r < 6) len = len + $urandom_range(1, 5);
    else if (r < 10 && len > 0) len = len - $urandom_range(1, len);
    else if (r < 12) len = $urandom;
    if (len < 128 && $urandom_range(3) != 0) begin
      add_byte(q, len[7:0]);
    end else begin
      nmin = (len == 0) ? 0 : (len < 32'h100) ? 1 : (len < 32'h10000) ? 2 :
             (len < 32'h1000000) ? 3 : 4;
      nb = $urandom_range(nmin, 4);
      add_byte(q, 8'h80 | nb[7:0]);
      for (int i = nb - 1; i >= 0; i--) add_byte(q, 8'(len >> (8 * i)));
    end
    foreach (body[i]) add_byte(q, body[i]);
  endfunction

  function automatic void build_buffer(ref logic [7:0] q[$]);
    int  r, n, max_lvl;
    bit  deep;
    r = $urandom_range(99);
    if (r < 10) begin
      // pure noise
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) add_byte(q, 8'($urandom));
    end else begin
      deep    = ($urandom_range(9) == 0);
      max_lvl = deep ? $urandom_range(8, 9) : $urandom_range(0, 3);
      n       = deep ? 1 : $urandom_range(1, 3);
      for (int i = 0; i < n; i++) gen_elem(0, max_lvl, deep, q);
      // cut the buffer short at a random byte
      if (r < 25) q = q[0:$urandom_range(0, q.size() - 1)];
    end
  endfunction

  task automatic send_byte(input logic [7:0] d, input logic l);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid     <= 1'b0;
      in_if.data_byte <= 8'($urandom);
      in_if.last_byte <= 1'($urandom);
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= d;
    in_if.last_byte <= l;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_buffer(input logic [7:0] q[$]);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
    buffers_sent++;
  endtask

  initial begin
    logic [7:0] buf_q[$];
    logic [7:0] chain[$];
    in_if.valid     = 1'b0;
    in_if.data_byte = 8'h00;
    in_if.last_byte = 1'b0;
    rst_n           = 1'b0;
    bytes_sent      = 0;
    buffers_sent    = 0;
    set_mode(MODE_STEADY);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // three-byte tag with the continuation bit still set on the third byte
    send_buffer('{8'h1F, 8'h81, 8'h81});
    // length count above four
    send_buffer('{8'h02, 8'hFF});
    // buffer ends right after an escape tag byte
    send_buffer('{8'h5F});
    // top-level end saturates, children are clamped, ninth level is too deep
    chain = '{8'hE0, 8'h84, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    repeat (MAX_NEST_TRY) begin
      add_byte(chain, 8'h20);
      add_byte(chain, 8'h7F);
    end
    send_buffer(chain);
    // empty constructed with 0x80 length, then a header running past its parent
    send_buffer('{8'h3F, 8'h81, 8'h01, 8'h80, 8'h21, 8'h02, 8'h5F, 8'h81, 8'h01});

    for (int m = MODE_STEADY; m <= MODE_BOTH; m++) begin
      set_mode(flow_mode_t'(m));
      while (bytes_sent < (m + 1) * RANDOM_BYTES / 4) begin
        buf_q.delete();
        build_buffer(buf_q);
        send_buffer(buf_q);
      end
    end
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d bytes in %0d buffers over steady, slow-source, slow-sink and mixed flow",
             bytes_sent, buffers_sent);
    $display("checked %0d element headers, %0d value bytes, %0d error results, nesting to %0d",
             n_elem, n_value, n_error, deepest);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d field mismatches", fail_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== ber_tlv_stream_parser.f =====
rtl/btp_pkg.sv
rtl/btp_if.sv
rtl/btp_cell.sv
rtl/btp_stack.sv
rtl/ber_tlv_stream_parser.sv
tb/btp_checker.sv
tb/testbench.sv
